[design/bwu_pkg.sv]
// shared types and constants of the barycentric weight unit
package bwu_pkg;

  localparam int CoordBits = 16;
  localparam int OutBits   = 24;
  localparam int DiffBits  = CoordBits + 1;
  localparam int ProdBits  = 2 * DiffBits;
  localparam int NumBits   = ProdBits + 1;

  typedef struct packed {
    logic signed [CoordBits-1:0] pix_x;
    logic signed [CoordBits-1:0] pix_y;
    logic signed [CoordBits-1:0] vert_a_x;
    logic signed [CoordBits-1:0] vert_a_y;
    logic signed [CoordBits-1:0] vert_b_x;
    logic signed [CoordBits-1:0] vert_b_y;
    logic signed [CoordBits-1:0] vert_c_x;
    logic signed [CoordBits-1:0] vert_c_y;
  } in_t;

  typedef struct packed {
    logic signed [OutBits-1:0] weight_alpha;
    logic signed [OutBits-1:0] weight_beta;
    logic signed [OutBits-1:0] weight_gamma;
    logic                      degenerate;
    logic                      saturated;
  } out_t;

  typedef struct packed {
    logic [NumBits-1:0] mag_a;
    logic [NumBits-1:0] mag_b;
    logic [NumBits-1:0] mag_area;
    logic               neg_a;
    logic               neg_b;
    logic               degen;
  } qent_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

[design/bwu_front.sv]
// front part: edge differences, cross products, sign and magnitude split
module bwu_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  bwu_pkg::in_t  in_data,
  input  logic          q_full,
  output logic          q_push,
  output bwu_pkg::qent_t q_entry
);
  import bwu_pkg::*;

  logic en;
  logic v1_r, v2_r;
  logic signed [DiffBits-1:0] abx_r, aby_r, acx_r, acy_r, bcx_r, bcy_r;
  logic signed [DiffBits-1:0] apx_r, apy_r, bpx_r, bpy_r;
  logic signed [ProdBits-1:0] p0_r, p1_r, p2_r, p3_r, p4_r, p5_r;
  logic signed [NumBits-1:0]  area, na, nb;

  assign en       = !(v2_r && q_full);
  assign in_stall = !en;
  assign q_push   = v2_r && !q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      abx_r <= DiffBits'(in_data.vert_b_x) - DiffBits'(in_data.vert_a_x);
      aby_r <= DiffBits'(in_data.vert_b_y) - DiffBits'(in_data.vert_a_y);
      acx_r <= DiffBits'(in_data.vert_c_x) - DiffBits'(in_data.vert_a_x);
      acy_r <= DiffBits'(in_data.vert_c_y) - DiffBits'(in_data.vert_a_y);
      bcx_r <= DiffBits'(in_data.vert_c_x) - DiffBits'(in_data.vert_b_x);
      bcy_r <= DiffBits'(in_data.vert_c_y) - DiffBits'(in_data.vert_b_y);
      apx_r <= DiffBits'(in_data.pix_x) - DiffBits'(in_data.vert_a_x);
      apy_r <= DiffBits'(in_data.pix_y) - DiffBits'(in_data.vert_a_y);
      bpx_r <= DiffBits'(in_data.pix_x) - DiffBits'(in_data.vert_b_x);
      bpy_r <= DiffBits'(in_data.pix_y) - DiffBits'(in_data.vert_b_y);
      p0_r  <= abx_r * acy_r;
      p1_r  <= aby_r * acx_r;
      p2_r  <= bcx_r * bpy_r;
      p3_r  <= bpx_r * bcy_r;
      p4_r  <= apx_r * acy_r;
      p5_r  <= acx_r * apy_r;
    end
  end

  always_comb begin
    area = NumBits'(p0_r) - NumBits'(p1_r);
    na   = NumBits'(p2_r) - NumBits'(p3_r);
    nb   = NumBits'(p4_r) - NumBits'(p5_r);
    q_entry.mag_area = area[NumBits-1] ? NumBits'(-area) : NumBits'(area);
    q_entry.mag_a    = na[NumBits-1] ? NumBits'(-na) : NumBits'(na);
    q_entry.mag_b    = nb[NumBits-1] ? NumBits'(-nb) : NumBits'(nb);
    q_entry.neg_a    = na[NumBits-1] ^ area[NumBits-1];
    q_entry.neg_b    = nb[NumBits-1] ^ area[NumBits-1];
    q_entry.degen    = (area == '0);
  end

endmodule

[design/bwu_queue.sv]
// two-entry queue between front and back
module bwu_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  bwu_pkg::qent_t wr_data,
  input  logic           pop,
  output bwu_pkg::qent_t rd_data,
  output bwu_pkg::qstat_t stat
);
  import bwu_pkg::*;

  qent_t      mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;

  assign rd_data    = mem_r[rd_ptr_r];
  assign stat.full  = (count_r == 2'd2);
  assign stat.empty = (count_r == 2'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
      count_r <= count_r + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= wr_data;
  end

endmodule

[design/bwu_back.sv]
// back part: pipelined restoring dividers, clipping and gamma
module bwu_back #(
  parameter int FRAC_BITS = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_empty,
  input  bwu_pkg::qent_t q_data,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_stall,
  output bwu_pkg::out_t  out_data
);
  import bwu_pkg::*;

  localparam int ShMax  = (FRAC_BITS > OutBits) ? FRAC_BITS : OutBits;
  localparam int RemW   = NumBits + ShMax + 1;
  localparam int GamW   = ((FRAC_BITS > OutBits) ? FRAC_BITS : OutBits) + 3;
  localparam int Stages = OutBits + 1;

  logic en;
  logic [Stages-1:0]       v_r;
  logic [RemW-1:0]         rem_a_r [Stages];
  logic [RemW-1:0]         rem_b_r [Stages];
  logic [NumBits-1:0]      den_r   [Stages];
  logic [OutBits-1:0]      q_a_r   [Stages];
  logic [OutBits-1:0]      q_b_r   [Stages];
  logic [Stages-1:0]       ovf_a_r, ovf_b_r, neg_a_r, neg_b_r, degen_r;
  logic                    vc_r, vo_r;
  logic signed [OutBits-1:0] wa_r, wb_r;
  logic                    sa_r, sb_r, dc_r;
  logic [RemW-1:0]         num_a0, num_b0, lim0;
  logic signed [OutBits-1:0] wa_c, wb_c;
  logic                    sa_c, sb_c;
  logic signed [GamW-1:0]  gam;
  logic signed [OutBits-1:0] gam_c;
  logic                    sg_c;

  function automatic logic [OutBits:0] clip_w(input logic ovf, input logic neg,
                                              input logic [OutBits-1:0] q);
    logic [OutBits-1:0] mx;
    logic [OutBits-1:0] mn;
    mx = {1'b0, {(OutBits-1){1'b1}}};
    mn = {1'b1, {(OutBits-1){1'b0}}};
    if (ovf) begin
      clip_w = {1'b1, neg ? mn : mx};
    end else if (!neg) begin
      clip_w = q[OutBits-1] ? {1'b1, mx} : {1'b0, q};
    end else if (q > mn) begin
      clip_w = {1'b1, mn};
    end else begin
      clip_w = {1'b0, OutBits'(-q)};
    end
  endfunction

  assign en        = !(vo_r && out_stall);
  assign q_pop     = en && !q_empty;
  assign out_valid = vo_r;

  assign num_a0 = RemW'(q_data.mag_a) << FRAC_BITS;
  assign num_b0 = RemW'(q_data.mag_b) << FRAC_BITS;
  assign lim0   = RemW'(q_data.mag_area) << OutBits;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r  <= '0;
      vc_r <= 1'b0;
      vo_r <= 1'b0;
    end else if (en) begin
      v_r  <= {v_r[Stages-2:0], !q_empty};
      vc_r <= v_r[Stages-1];
      vo_r <= vc_r;
    end
  end

  // stage 0 checks the quotient against the output span, then one bit per stage
  always_ff @(posedge clk) begin
    if (en) begin
      rem_a_r[0] <= num_a0;
      rem_b_r[0] <= num_b0;
      den_r[0]   <= q_data.mag_area;
      q_a_r[0]   <= '0;
      q_b_r[0]   <= '0;
      ovf_a_r[0] <= (num_a0 >= lim0);
      ovf_b_r[0] <= (num_b0 >= lim0);
      neg_a_r[0] <= q_data.neg_a;
      neg_b_r[0] <= q_data.neg_b;
      degen_r[0] <= q_data.degen;
      for (int s = 1; s < Stages; s++) begin
        den_r[s]   <= den_r[s-1];
        ovf_a_r[s] <= ovf_a_r[s-1];
        ovf_b_r[s] <= ovf_b_r[s-1];
        neg_a_r[s] <= neg_a_r[s-1];
        neg_b_r[s] <= neg_b_r[s-1];
        degen_r[s] <= degen_r[s-1];
        if (rem_a_r[s-1] >= (RemW'(den_r[s-1]) << (OutBits - s))) begin
          rem_a_r[s] <= rem_a_r[s-1] - (RemW'(den_r[s-1]) << (OutBits - s));
          q_a_r[s]   <= q_a_r[s-1] | (OutBits'(1) << (OutBits - s));
        end else begin
          rem_a_r[s] <= rem_a_r[s-1];
          q_a_r[s]   <= q_a_r[s-1];
        end
        if (rem_b_r[s-1] >= (RemW'(den_r[s-1]) << (OutBits - s))) begin
          rem_b_r[s] <= rem_b_r[s-1] - (RemW'(den_r[s-1]) << (OutBits - s));
          q_b_r[s]   <= q_b_r[s-1] | (OutBits'(1) << (OutBits - s));
        end else begin
          rem_b_r[s] <= rem_b_r[s-1];
          q_b_r[s]   <= q_b_r[s-1];
        end
      end
    end
  end

  always_comb begin
    {sa_c, wa_c} = clip_w(ovf_a_r[Stages-1], neg_a_r[Stages-1], q_a_r[Stages-1]);
    {sb_c, wb_c} = clip_w(ovf_b_r[Stages-1], neg_b_r[Stages-1], q_b_r[Stages-1]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      wa_r <= wa_c;
      wb_r <= wb_c;
      sa_r <= sa_c;
      sb_r <= sb_c;
      dc_r <= degen_r[Stages-1];
    end
  end

  always_comb begin
    gam   = (GamW'(1) << FRAC_BITS) - GamW'(wa_r) - GamW'(wb_r);
    sg_c  = 1'b0;
    gam_c = OutBits'(gam);
    if (gam > $signed(GamW'({1'b0, {(OutBits-1){1'b1}}}))) begin
      sg_c  = 1'b1;
      gam_c = {1'b0, {(OutBits-1){1'b1}}};
    end else if (gam < -(GamW'(1) << (OutBits - 1))) begin
      sg_c  = 1'b1;
      gam_c = {1'b1, {(OutBits-1){1'b0}}};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data.degenerate   <= dc_r;
      out_data.weight_alpha <= dc_r ? '0 : wa_r;
      out_data.weight_beta  <= dc_r ? '0 : wb_r;
      out_data.weight_gamma <= dc_r ? '0 : gam_c;
      out_data.saturated    <= !dc_r && (sa_r || sb_r || sg_c);
    end
  end

endmodule

[design/barycentric_weight_unit_core.sv]
// top level of the barycentric weight unit
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_stall  | in_data (pixel and three vertices)
//  out     | output    | out_valid/out_stall| out_data (three weights and flags)
// one item per cycle sustained while the output is not stalled; the path runs through two front stages for
// differences and products, the queue, one range check stage, 24 quotient
// stages (one bit each) and the clip and gamma stages
// reset clears all valid bits and the queue count; no clearing pass
// a stalled output freezes the back part; the front keeps going until the
// two-entry queue fills, then stalls the input
module barycentric_weight_unit_core #(
  parameter int FRAC_BITS = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  bwu_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output bwu_pkg::out_t out_data
);
  import bwu_pkg::*;

  qent_t  push_data, pop_data;
  qstat_t q_stat;
  logic   q_push, q_pop;

  bwu_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_stat.full),
    .q_push   (q_push),
    .q_entry  (push_data)
  );

  bwu_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_data (push_data),
    .pop     (q_pop),
    .rd_data (pop_data),
    .stat    (q_stat)
  );

  bwu_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_stat.empty),
    .q_data    (pop_data),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  a_queue_state: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_stat.full && q_stat.empty))
    else $error("queue full and empty at once");

  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.degenerate |->
      out_data.weight_alpha == '0 && out_data.weight_beta == '0 &&
      out_data.weight_gamma == '0 && !out_data.saturated)
    else $error("degenerate item with nonzero weights");

  a_weight_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.degenerate && !out_data.saturated |->
      (OutBits + 3)'(out_data.weight_alpha) + (OutBits + 3)'(out_data.weight_beta)
      + (OutBits + 3)'(out_data.weight_gamma) == ((OutBits + 3)'(1) << FRAC_BITS))
    else $error("weights do not sum to one");

  a_pop_only_data: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_stat.empty)
    else $error("queue read while empty");

endmodule

[bench/barycentric_weight_unit_core_chk.sv]
// checker that predicts barycentric weights and compares each result item
module barycentric_weight_unit_core_chk (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_stall,
  input  bwu_pkg::in_t  in_data,
  input  logic          out_valid,
  input  logic          out_stall,
  input  bwu_pkg::out_t out_data,
  output int            err_cnt,
  output int            pend_cnt
);
  import bwu_pkg::*;

  localparam int FracBits = 16;
  localparam longint WMax = (64'sd1 <<< (OutBits - 1)) - 1;
  localparam longint WMin = -WMax - 1;

  out_t weights_due[$];

  function automatic longint clip_w(longint v, ref bit sat);
    if (v > WMax) begin
      sat = 1;
      return WMax;
    end
    if (v < WMin) begin
      sat = 1;
      return WMin;
    end
    return v;
  endfunction

  function automatic longint frac_quot(longint num, longint den, ref bit sat);
    bit neg;
    longint unsigned n, d, q, r;
    neg = (num < 0) != (den < 0);
    n = num < 0 ? -num : num;
    d = den < 0 ? -den : den;
    q = n / d;
    r = n % d;
    if (q > (64'd1 << OutBits)) q = 64'd1 << OutBits;
    for (int i = 0; i < FracBits; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= d) begin
        r = r - d;
        q = q | 64'd1;
      end
    end
    return clip_w(neg ? -longint'(q) : longint'(q), sat);
  endfunction

  function automatic out_t bary_weights(in_t p);
    longint px, py, ax, ay, bx, by, cx, cy, area, na, nb, wa, wb, wg;
    bit sat;
    out_t o;
    px = p.pix_x;    py = p.pix_y;
    ax = p.vert_a_x; ay = p.vert_a_y;
    bx = p.vert_b_x; by = p.vert_b_y;
    cx = p.vert_c_x; cy = p.vert_c_y;
    area = (bx - ax) * (cy - ay) - (by - ay) * (cx - ax);
    sat = 0;
    wa = 0;
    wb = 0;
    wg = 0;
    if (area != 0) begin
      na = (cx - bx) * (py - by) - (px - bx) * (cy - by);
      nb = (px - ax) * (cy - ay) - (cx - ax) * (py - ay);
      wa = frac_quot(na, area, sat);
      wb = frac_quot(nb, area, sat);
      wg = clip_w((64'sd1 <<< FracBits) - wa - wb, sat);
    end
    o.weight_alpha = wa[OutBits-1:0];
    o.weight_beta  = wb[OutBits-1:0];
    o.weight_gamma = wg[OutBits-1:0];
    o.degenerate   = (area == 0);
    o.saturated    = sat;
    return o;
  endfunction

  always @(posedge clk) begin
    out_t want;
    if (!rst_n) err_cnt = 0;
    if (rst_n && in_valid && !in_stall) weights_due.push_back(bary_weights(in_data));
    if (rst_n && out_valid && !out_stall) begin
      if (weights_due.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected item %h", $time, out_data);
      end else begin
        want = weights_due.pop_front();
        if (out_data.weight_alpha !== want.weight_alpha)
          $display("%0t: alpha exp %h got %h", $time, want.weight_alpha, out_data.weight_alpha);
        if (out_data.weight_beta !== want.weight_beta)
          $display("%0t: beta exp %h got %h", $time, want.weight_beta, out_data.weight_beta);
        if (out_data.weight_gamma !== want.weight_gamma)
          $display("%0t: gamma exp %h got %h", $time, want.weight_gamma, out_data.weight_gamma);
        if (out_data.degenerate !== want.degenerate)
          $display("%0t: degenerate exp %b got %b", $time, want.degenerate,
                   out_data.degenerate);
        if (out_data.saturated !== want.saturated)
          $display("%0t: saturated exp %b got %b", $time, want.saturated, out_data.saturated);
        if (out_data !== want) err_cnt++;
      end
    end
    pend_cnt = weights_due.size();
  end
endmodule

[bench/barycentric_weight_unit_core_tb.sv]
// stimulus and verdict for the barycentric weight unit
module barycentric_weight_unit_core_tb;
  import bwu_pkg::*;

  logic clk, rst_n, in_valid, in_stall, out_valid, out_stall;
  in_t  in_data;
  out_t out_data;
  int   err_cnt, pend_cnt;
  int   in_idle_pct, out_stall_pct;

  barycentric_weight_unit_core uut (.*);

  barycentric_weight_unit_core_chk chk (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20000000;
    $display("barycentric_weight_unit_core_tb: errors");
    $finish;
  end

  always @(posedge clk) out_stall <= ($urandom_range(99) < out_stall_pct);

  function automatic logic [15:0] rand_coord();
    case ($urandom_range(5))
      0: return 16'(16'h7fff - $urandom_range(3));
      1: return 16'(16'h8000 + $urandom_range(3));
      2: return 16'($urandom_range(31) - 16);
      3: return 16'($urandom_range(2047) - 1024);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic in_t rand_tri();
    in_t t;
    t = {rand_coord(), rand_coord(), rand_coord(), rand_coord(),
         rand_coord(), rand_coord(), rand_coord(), rand_coord()};
    case ($urandom_range(9))
      0: t.vert_b_x = t.vert_a_x;
      1: begin
        t.vert_c_x = t.vert_a_x;
        t.vert_c_y = t.vert_a_y;
      end
      2: begin
        t.pix_x = t.vert_a_x;
        t.pix_y = t.vert_a_y;
      end
      3: t = $urandom ^ {$urandom, $urandom, $urandom, $urandom};
      default: ;
    endcase
    return t;
  endfunction

  task automatic send_tri(in_t t);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_data  <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic run_phase(int n, int idle_pct, int stall_pct);
    in_idle_pct = idle_pct;
    out_stall_pct = stall_pct;
    repeat (n) send_tri(rand_tri());
  endtask

  initial begin
    in_t t;
    in_valid = 0;
    in_data = '0;
    in_idle_pct = 0;
    out_stall_pct = 0;
    rst_n = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1;
    // directed: unit triangle, corners, degenerate, extremes, huge weights
    send_tri({16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd10, 16'sd0, 16'sd0, 16'sd10});
    send_tri({16'sd3, 16'sd4, 16'sd0, 16'sd0, 16'sd10, 16'sd0, 16'sd0, 16'sd10});
    send_tri({16'sd10, 16'sd0, 16'sd0, 16'sd0, 16'sd10, 16'sd0, 16'sd0, 16'sd10});
    send_tri({16'sd0, 16'sd10, 16'sd0, 16'sd0, 16'sd10, 16'sd0, 16'sd0, 16'sd10});
    send_tri({16'sd5, 16'sd5, 16'sd1, 16'sd1, 16'sd2, 16'sd2, 16'sd3, 16'sd3});
    send_tri({16'sd5, 16'sd5, 16'sd1, 16'sd1, 16'sd1, 16'sd1, 16'sd1, 16'sd1});
    send_tri({16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh8001, 16'sh8000,
              16'sh8000, 16'sh8001});
    send_tri({16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh8000,
              16'sh7fff, 16'sh7fff});
    send_tri({16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh7fff,
              16'sh8000, 16'sh8000});
    send_tri({16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh7fff,
              16'sh7fff, 16'sh8000});
    send_tri({16'sd0, 16'sd0, 16'sd10, 16'sd10, 16'sd0, 16'sd10, 16'sd10, 16'sd0});
    send_tri({16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd10, 16'sd10, 16'sd0});
    send_tri('1);
    send_tri('0);
    run_phase(400, 0, 0);
    in_valid <= 0;
    // hold off until the pipe drains
    while (pend_cnt != 0) @(posedge clk);
    run_phase(150, 86, 0);
    run_phase(150, 0, 86);
    run_phase(150, 26, 26);
    run_phase(300, 0, 0);
    in_valid <= 0;
    out_stall_pct = 0;
    while (pend_cnt != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (err_cnt == 0 && pend_cnt == 0)
      $display("barycentric_weight_unit_core_tb: clean");
    else
      $display("barycentric_weight_unit_core_tb: errors");
    $finish;
  end
endmodule

[files.f]
design/bwu_pkg.sv
design/bwu_front.sv
design/bwu_queue.sv
design/bwu_back.sv
design/barycentric_weight_unit_core.sv
bench/barycentric_weight_unit_core_chk.sv
bench/barycentric_weight_unit_core_tb.sv
